// File: hdl/hdm_pkg.sv
// ============================================================================
// hdm_pkg
// Shared types, codes and helpers for the Hamming descriptor matcher.
// ============================================================================
package hdm_pkg;

    localparam int HDM_MAX_REFS = 1024;
    localparam int DESC_BITS    = 256;
    localparam int WORD_BITS    = 64;
    localparam int DESC_WORDS   = DESC_BITS / WORD_BITS;
    localparam int KEY_BITS     = 24;
    localparam int DIST_W       = 10;
    localparam int POP_W        = 7;
    localparam int HD_W         = 9;
    localparam int CNT_W        = 16;
    localparam int OUT_IDX_W    = 10;

    localparam logic [DIST_W-1:0] NO_DIST   = 10'd999;
    localparam logic [CNT_W-1:0]  CAP_RESET = 16'd4096;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [63:0] desc_word0;
        logic [63:0] desc_word1;
        logic [63:0] desc_word2;
        logic [63:0] desc_word3;
        logic [11:0] key_x;
        logic [11:0] key_y;
    } in_item_t;

    typedef struct packed {
        logic        matched;
        logic [15:0] match_number;
        logic [9:0]  ref_index;
        logic [11:0] ref_x;
        logic [11:0] ref_y;
        logic [11:0] query_x;
        logic [11:0] query_y;
        logic [9:0]  best_distance;
        logic [9:0]  second_distance;
    } out_item_t;

    typedef struct packed {
        logic clear;
        logic load;
        logic query;
        logic issue;
        logic key_read;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic ref_empty;
        logic issue_last;
        logic pipe_busy;
        logic out_free;
    } dp_stat_t;

    function automatic logic [POP_W-1:0] pop64(input logic [WORD_BITS-1:0] v);
        logic [WORD_BITS-1:0] s1;
        logic [WORD_BITS-1:0] s2;
        logic [WORD_BITS-1:0] s3;
        logic [POP_W-1:0]     sum;
        s1 = v - ((v >> 1) & 64'h5555555555555555);
        s2 = (s1 & 64'h3333333333333333) + ((s1 >> 2) & 64'h3333333333333333);
        s3 = (s2 + (s2 >> 4)) & 64'h0F0F0F0F0F0F0F0F;
        sum = '0;
        for (int b = 0; b < 8; b++)
        begin
            sum = sum + {3'b000, s3[b*8 +: 4]};
        end
        return sum;
    endfunction

endpackage

// File: hdl/hamming_descriptor_matcher_core.sv
// ============================================================================
// hamming_descriptor_matcher_core
// Brute-force Hamming matcher for 256-bit descriptors with a ratio test.
// ============================================================================
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------
//  in      | into core | in_valid / in_stall  | in_data  (in_item_t)
//  out     | from core | out_valid / out_stall| out_data (out_item_t)
//  cfg     | into core | cfg_valid / cfg_ready| cfg_data (match cap)
//
//  Clear and load are each done as they are accepted. A query reads one
//  reference per cycle from the descriptor RAM (none with an empty table),
//  then the RAM read, popcount and compare stages drain, a keypoint RAM
//  read follows and the result register is written.
//  Reset: rst_n clears the counters, the match cap (to 4096) and all control;
//  the reference RAMs hold no reset value; a read past the count is discarded.
//  A stalled result holds in the output register; the core keeps taking
//  clears and loads behind it and waits only to write the next query result.
//
module hamming_descriptor_matcher_core #(
    parameter int MAX_REFS = hdm_pkg::HDM_MAX_REFS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  hdm_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output hdm_pkg::out_item_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [15:0]        cfg_data
);
    import hdm_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    hdm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_op    (in_data.op),
        .in_stall (in_stall),
        .cmd      (cmd),
        .stat     (stat)
    );

    hdm_datapath #(.MAX_REFS(MAX_REFS)) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

// File: hdl/hdm_ram.sv
// ============================================================================
// hdm_ram
// Simple dual-port RAM: one write port, one registered read port.
// ============================================================================
module hdm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: hdl/hdm_ctrl.sv
// ============================================================================
// hdm_ctrl
// Sequencer: accepts items, steps the reference scan and hands off results.
// ============================================================================
module hdm_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [1:0]       in_op,
    output logic             in_stall,
    output hdm_pkg::dp_cmd_t cmd,
    input  hdm_pkg::dp_stat_t stat
);
    import hdm_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_op)
                        OP_CLEAR: cmd.clear = 1'b1;
                        OP_LOAD:  cmd.load  = 1'b1;
                        OP_QUERY:
                        begin
                            cmd.query  = 1'b1;
                            state_next = stat.ref_empty ? ST_DRAIN : ST_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN:
            begin
                cmd.issue = 1'b1;
                if (stat.issue_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!stat.pipe_busy)
                begin
                    cmd.key_read = 1'b1;
                    state_next   = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: hdl/hdm_datapath.sv
// ============================================================================
// hdm_datapath
// Reference tables, distance pipeline, best/second tracking and result register.
// ============================================================================
module hdm_datapath #(
    parameter int MAX_REFS = hdm_pkg::HDM_MAX_REFS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  hdm_pkg::in_item_t  in_data,
    input  hdm_pkg::dp_cmd_t   cmd,
    output hdm_pkg::dp_stat_t  stat,
    input  logic               cfg_valid,
    input  logic [15:0]        cfg_data,
    input  logic               out_stall,
    output logic               out_valid,
    output hdm_pkg::out_item_t out_data
);
    import hdm_pkg::*;

    localparam int IW = $clog2(MAX_REFS);
    localparam int CW = $clog2(MAX_REFS + 1);

    logic [CW-1:0]        ref_count_reg;
    logic [CNT_W-1:0]     match_count_reg;
    logic [CNT_W-1:0]     match_count_next;
    logic [CNT_W-1:0]     match_cap_reg;
    logic [DESC_BITS-1:0] q_desc_reg;
    logic [11:0]          qx_reg;
    logic [11:0]          qy_reg;
    logic [IW-1:0]        scan_addr_reg;
    logic                 rd_valid_reg;
    logic [IW-1:0]        rd_idx_reg;
    logic [POP_W-1:0]     pc_reg [DESC_WORDS];
    logic                 pc_valid_reg;
    logic [IW-1:0]        pc_idx_reg;
    logic [DIST_W-1:0]    best1_reg;
    logic [DIST_W-1:0]    best2_reg;
    logic [IW-1:0]        best_idx_reg;
    logic                 found_reg;
    logic                 out_valid_reg;
    out_item_t            out_reg;

    logic                 load_ok;
    logic [DESC_BITS-1:0] in_desc;
    logic [DESC_BITS-1:0] ref_desc;
    logic [DESC_BITS-1:0] diff;
    logic [KEY_BITS-1:0]  ref_key;
    logic [HD_W-1:0]      hd;
    logic [DIST_W-1:0]    hd_ext;
    logic [DIST_W+1:0]    three_b2;
    logic                 ok;
    logic [IW+OUT_IDX_W-1:0] idx_ext;

    assign in_desc = {in_data.desc_word3, in_data.desc_word2,
                      in_data.desc_word1, in_data.desc_word0};
    assign load_ok = (ref_count_reg < CW'(MAX_REFS));

    hdm_ram #(.WIDTH(DESC_BITS), .DEPTH(MAX_REFS)) u_desc_ram (
        .clk     (clk),
        .wr_en   (cmd.load && load_ok),
        .wr_addr (ref_count_reg[IW-1:0]),
        .wr_data (in_desc),
        .rd_en   (cmd.issue),
        .rd_addr (scan_addr_reg),
        .rd_data (ref_desc)
    );

    hdm_ram #(.WIDTH(KEY_BITS), .DEPTH(MAX_REFS)) u_key_ram (
        .clk     (clk),
        .wr_en   (cmd.load && load_ok),
        .wr_addr (ref_count_reg[IW-1:0]),
        .wr_data ({in_data.key_y, in_data.key_x}),
        .rd_en   (cmd.key_read),
        .rd_addr (best_idx_reg),
        .rd_data (ref_key)
    );

    assign diff   = ref_desc ^ q_desc_reg;
    assign hd     = {2'b00, pc_reg[0]} + {2'b00, pc_reg[1]}
                  + {2'b00, pc_reg[2]} + {2'b00, pc_reg[3]};
    assign hd_ext = {1'b0, hd};

    assign three_b2 = {2'b00, best2_reg} + {1'b0, best2_reg, 1'b0};
    assign ok = found_reg && (match_count_reg < match_cap_reg)
             && (best1_reg < three_b2[DIST_W+1:2]);
    assign match_count_next = ok ? match_count_reg + 1'b1 : match_count_reg;
    assign idx_ext = {{OUT_IDX_W{1'b0}}, best_idx_reg};

    assign stat.ref_empty  = (ref_count_reg == '0);
    assign stat.issue_last = (CW'(scan_addr_reg) == ref_count_reg - 1'b1);
    assign stat.pipe_busy  = rd_valid_reg || pc_valid_reg;
    assign stat.out_free   = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_count_reg   <= '0;
            match_count_reg <= '0;
            match_cap_reg   <= CAP_RESET;
            scan_addr_reg   <= '0;
            rd_valid_reg    <= 1'b0;
            pc_valid_reg    <= 1'b0;
            best1_reg       <= NO_DIST;
            best2_reg       <= NO_DIST;
            best_idx_reg    <= '0;
            found_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                match_cap_reg <= cfg_data;
            end
            if (cmd.clear)
            begin
                ref_count_reg   <= '0;
                match_count_reg <= '0;
            end
            if (cmd.load && load_ok)
            begin
                ref_count_reg <= ref_count_reg + 1'b1;
            end
            rd_valid_reg <= cmd.issue;
            pc_valid_reg <= rd_valid_reg;
            if (cmd.query)
            begin
                scan_addr_reg <= '0;
                best1_reg     <= NO_DIST;
                best2_reg     <= NO_DIST;
                best_idx_reg  <= '0;
                found_reg     <= 1'b0;
            end
            else if (cmd.issue)
            begin
                scan_addr_reg <= scan_addr_reg + 1'b1;
            end
            if (pc_valid_reg)
            begin
                if (hd_ext < best1_reg)
                begin
                    best2_reg    <= best1_reg;
                    best1_reg    <= hd_ext;
                    best_idx_reg <= pc_idx_reg;
                    found_reg    <= 1'b1;
                end
                else if (hd_ext < best2_reg)
                begin
                    best2_reg <= hd_ext;
                end
            end
            if (cmd.finish)
            begin
                match_count_reg <= match_count_next;
                out_valid_reg   <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.query)
        begin
            q_desc_reg <= in_desc;
            qx_reg     <= in_data.key_x;
            qy_reg     <= in_data.key_y;
        end
        rd_idx_reg <= scan_addr_reg;
        pc_idx_reg <= rd_idx_reg;
        for (int w = 0; w < DESC_WORDS; w++)
        begin
            pc_reg[w] <= pop64(diff[w*WORD_BITS +: WORD_BITS]);
        end
        if (cmd.finish)
        begin
            out_reg.matched         <= ok;
            out_reg.match_number    <= match_count_next;
            out_reg.ref_index       <= found_reg ? idx_ext[OUT_IDX_W-1:0] : '0;
            out_reg.ref_x           <= found_reg ? ref_key[11:0] : '0;
            out_reg.ref_y           <= found_reg ? ref_key[23:12] : '0;
            out_reg.query_x         <= qx_reg;
            out_reg.query_y         <= qy_reg;
            out_reg.best_distance   <= best1_reg;
            out_reg.second_distance <= best2_reg;
        end
    end

endmodule
